// File: sv/pal_pkg.sv
// Shared constants, command and status codes, and cell control types of the array list.
package pal_pkg;

    localparam int DEPTH  = 64;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 3;
    localparam int LEAVES = 1 << IDX_W;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_READ   = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_DELETE = 3'd4,
        CMD_SEARCH = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_INVALID   = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_FOUND     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        cnt_t     pos;
        cnt_t     count;
        word_t    data;
        logic     cmp;
    } cell_ctrl_t;

endpackage

// File: sv/pal_cell.sv
// One storage cell of the list chain: holds one entry and its search match flag.
module pal_cell
    import pal_pkg::*;
(
    input  logic       aclk,
    input  cnt_t       cell_idx,
    input  cell_ctrl_t ctrl,
    input  word_t      left_val,
    input  word_t      right_val,
    output word_t      val,
    output logic       match
);

    word_t val_reg;
    word_t val_next;
    logic  match_reg;
    logic  match_next;

    always_comb begin
        val_next   = val_reg;
        match_next = match_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                if (cell_idx == ctrl.pos) begin
                    val_next = ctrl.data;
                end else if (cell_idx > ctrl.pos) begin
                    val_next = left_val;
                end
            end
            CELL_DELETE: begin
                if (cell_idx >= ctrl.pos) begin
                    val_next = right_val;
                end
            end
            CELL_ROTATE: begin
                val_next = right_val;
            end
            default: begin
            end
        endcase
        if (ctrl.cmp) begin
            match_next = (val_reg == ctrl.data) && (cell_idx < ctrl.count);
        end
    end

    always_ff @(posedge aclk) begin
        val_reg   <= val_next;
        match_reg <= match_next;
    end

    assign val   = val_reg;
    assign match = match_reg;

endmodule

// File: sv/pal_first.sv
// Binary tree that finds the lowest cell whose match flag is set.
module pal_first
    import pal_pkg::*;
(
    input  logic [DEPTH-1:0] match,
    output logic             found,
    output idx_t             first_idx
);

    logic node_f  [1:2*LEAVES-1];
    idx_t node_ix [1:2*LEAVES-1];

    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < DEPTH) begin : g_used
            assign node_f[LEAVES+i] = match[i];
        end else begin : g_pad
            assign node_f[LEAVES+i] = 1'b0;
        end
        assign node_ix[LEAVES+i] = IDX_W'(i);
    end

    // the lower half wins, so the first match rises to the root
    for (genvar n = 1; n < LEAVES; n++) begin : g_node
        assign node_f[n]  = node_f[2*n] | node_f[2*n+1];
        assign node_ix[n] = node_f[2*n] ? node_ix[2*n] : node_ix[2*n+1];
    end

    assign found     = node_f[1];
    assign first_idx = node_ix[1];

endmodule

// File: sv/positional_array_list.sv
// Top level of the array list: command decode, sequencer, cell chain and result register.
//
//  channel | ports                | tdata fields, lowest bit first
//  --------+----------------------+-----------------------------------------------------
//  command | s_axis_t{valid,ready,| cmd[2:0] position[9:3] operand_value[41:10], pad 0
//          | data}                |
//  result  | m_axis_t{valid,ready,| status[2:0] element_value[34:3] element_index[40:35]
//          | data,last}           | entry_count[47:41]; tlast marks the final result
//
// Clear, append, insert and delete need no sequencing: every cell shifts, loads or holds at once.
// Search: the cells compare in the accept cycle, the match tree resolves next.
// Read out: after the accept cycle, one rotation per result transfer for count results, then
// DEPTH - count free-running rotations to restore the original order.
// Synchronous active-low reset empties the list; cell contents are not cleared.
// A stalled result holds the result register and pauses read out; the restoring turn runs on.
// A command is taken only while the sequencer is idle and the result register is free or
// being drained.
module positional_array_list
    import pal_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cmd, position, operand_value, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status, element_value, element_index, entry_count
    output logic        m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_READ,
        S_ROT
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    cnt_t    rd_reg, rd_next;
    logic    mv_reg, mv_next;
    status_t st_reg, st_next;
    word_t   val_reg, val_next;
    idx_t    idx_reg, idx_next;
    cnt_t    ocnt_reg, ocnt_next;
    logic    last_reg, last_next;

    logic  [CMD_W-1:0] in_cmd;
    cnt_t              in_pos;
    word_t             in_val;
    logic              out_free;
    logic              s_acc;
    logic              load;
    cell_ctrl_t        ctrl;

    word_t             cell_val [DEPTH];
    logic  [DEPTH-1:0] cell_match;
    logic              found;
    idx_t              first_idx;

    assign in_cmd = s_axis_tdata[2:0];
    assign in_pos = s_axis_tdata[9:3];
    assign in_val = s_axis_tdata[41:10];

    // free when empty or being taken in this cycle
    assign out_free      = !mv_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // ---- cell chain: cell i shifts in from i-1 on insert, from i+1 on delete and rotate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        word_t left_v;
        word_t right_v;
        if (i == 0) begin : g_first
            assign left_v = '0;
        end else begin : g_mid_l
            assign left_v = cell_val[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_v = cell_val[0];
        end else begin : g_mid_r
            assign right_v = cell_val[i+1];
        end
        pal_cell u_cell (
            .aclk      (aclk),
            .cell_idx  (CNT_W'(i)),
            .ctrl      (ctrl),
            .left_val  (left_v),
            .right_val (right_v),
            .val       (cell_val[i]),
            .match     (cell_match[i])
        );
    end

    pal_first u_first (
        .match     (cell_match),
        .found     (found),
        .first_idx (first_idx)
    );

    // ---- sequencer and result register
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rd_next    = rd_reg;
        mv_next    = mv_reg && !m_axis_tready;
        st_next    = st_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        ocnt_next  = ocnt_reg;
        last_next  = last_reg;
        load       = 1'b0;
        ctrl.op    = CELL_HOLD;
        ctrl.pos   = in_pos;
        ctrl.count = count_reg;
        ctrl.data  = in_val;
        ctrl.cmp   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    val_next  = '0;
                    idx_next  = '0;
                    last_next = 1'b1;
                    unique case (in_cmd)
                        CMD_CLEAR: begin
                            count_next = '0;
                            load       = 1'b1;
                            st_next    = STAT_OK;
                        end
                        CMD_APPEND: begin
                            load = 1'b1;
                            if (count_reg >= CNT_W'(DEPTH)) begin
                                st_next = STAT_FULL;
                            end else begin
                                ctrl.op    = CELL_INSERT;
                                ctrl.pos   = count_reg;
                                count_next = count_reg + 1'b1;
                                st_next    = STAT_OK;
                            end
                        end
                        CMD_READ: begin
                            if (count_reg == '0) begin
                                load    = 1'b1;
                                st_next = STAT_EMPTY;
                            end else begin
                                rd_next    = '0;
                                state_next = S_READ;
                            end
                        end
                        CMD_INSERT: begin
                            load = 1'b1;
                            if (in_pos > count_reg) begin
                                st_next = STAT_INVALID;
                            end else if (count_reg >= CNT_W'(DEPTH)) begin
                                st_next = STAT_FULL;
                            end else begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                                st_next    = STAT_OK;
                            end
                        end
                        CMD_DELETE: begin
                            load = 1'b1;
                            if (in_pos >= count_reg) begin
                                st_next = STAT_INVALID;
                            end else begin
                                ctrl.op    = CELL_DELETE;
                                count_next = count_reg - 1'b1;
                                st_next    = STAT_OK;
                            end
                        end
                        CMD_SEARCH: begin
                            ctrl.cmp   = 1'b1;
                            state_next = S_SRCH;
                        end
                        default: begin
                            // undefined codes: drop silently
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (out_free) begin
                    load       = 1'b1;
                    st_next    = found ? STAT_FOUND : STAT_NOT_FOUND;
                    val_next   = '0;
                    idx_next   = found ? first_idx : '0;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    load      = 1'b1;
                    ctrl.op   = CELL_ROTATE;
                    st_next   = STAT_OK;
                    val_next  = cell_val[0];
                    idx_next  = rd_reg[IDX_W-1:0];
                    last_next = (cnt_t'(rd_reg + 1'b1) == count_reg);
                    rd_next   = rd_reg + 1'b1;
                    if (last_next) begin
                        state_next = (count_reg == CNT_W'(DEPTH)) ? S_IDLE : S_ROT;
                    end
                end
            end
            S_ROT: begin
                // finish the full turn so entry 0 sits in cell 0 again
                ctrl.op = CELL_ROTATE;
                rd_next = rd_reg + 1'b1;
                if (rd_reg == CNT_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (load) begin
            mv_next   = 1'b1;
            ocnt_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
        rd_reg   <= rd_next;
        st_reg   <= st_next;
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        ocnt_reg <= ocnt_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = {ocnt_reg, idx_reg, val_reg, st_reg};
    assign m_axis_tlast  = last_reg;

    // ---- checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("command taken while sequencer busy");

    a_count_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_acc |=> (count_reg == $past(count_reg)))
        else $error("entry count changed without a command");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> (rd_reg < count_reg))
        else $error("read out index beyond entry count");

endmodule
